[rtl/bbspi_pkg.sv]
// ----------------------------------------------------------------------------
// bbspi_pkg
// Shared types and constants for the bit-bang SPI master core.
// ----------------------------------------------------------------------------
package bbspi_pkg;

  localparam int COUNT_BITS  = 16;  // width of the byte counter (8..32)
  localparam int HALF_STEPS  = 16;  // half-bit steps per byte
  localparam int HALF_BITS   = 4;   // bits that index a half-step
  localparam int HALF_CNT_W  = 5;   // half-step counter, holds HALF_STEPS itself
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [7:0] MSB_MASK = 8'h80;
  localparam logic [7:0] LSB_MASK = 8'h01;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOFT_ENABLE    = 3'd0,
    REG_CLOCK_POLARITY = 3'd1,
    REG_CLOCK_PHASE    = 3'd2,
    REG_LSB_FIRST      = 3'd3,
    REG_BAUD_DIVIDER   = 3'd4,
    REG_START_HOLD     = 3'd5,
    REG_END_HOLD       = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_START      = 3'd0,
    PH_LOAD_HOLD  = 3'd1,
    PH_START_HOLD = 3'd2,
    PH_BYTE       = 3'd3,  // byte fetch, or end hold when no bytes remain
    PH_SHIFT      = 3'd4
  } phase_t;

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  typedef struct packed {
    logic       soft_enable;
    logic       clock_polarity;
    logic       clock_phase;
    logic       lsb_first;
    logic [7:0] baud_divider;
    logic [7:0] start_hold;
    logic [7:0] end_hold;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] byte_count;
    logic [7:0]  tx_data;
    logic        miso;
  } in_item_t;

  typedef struct packed {
    logic       clk_update;
    logic       clk_level;
    logic       mosi_update;
    logic       mosi_level;
    logic       start_event;
    logic       end_event;
    logic       byte_done;
    logic [7:0] rx_byte;
    logic       tx_taken;
  } out_item_t;

endpackage

[rtl/bbspi_if.sv]
// ----------------------------------------------------------------------------
// bbspi_if
// Valid/ready channels for command items and step results.
// ----------------------------------------------------------------------------
interface bbspi_in_if;
  logic                 valid;
  logic                 ready;
  bbspi_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bbspi_out_if;
  logic                 valid;
  logic                 ready;
  bbspi_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/bbspi_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bbspi_cfg_regs
// Write-only configuration registers.
// ----------------------------------------------------------------------------
module bbspi_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bbspi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbspi_pkg::CFG_DATA_W-1:0] cfg_data,
  output bbspi_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bbspi_pkg::REG_SOFT_ENABLE:    cfg.soft_enable    <= cfg_data[0];
        bbspi_pkg::REG_CLOCK_POLARITY: cfg.clock_polarity <= cfg_data[0];
        bbspi_pkg::REG_CLOCK_PHASE:    cfg.clock_phase    <= cfg_data[0];
        bbspi_pkg::REG_LSB_FIRST:      cfg.lsb_first      <= cfg_data[0];
        bbspi_pkg::REG_BAUD_DIVIDER:   cfg.baud_divider   <= cfg_data[7:0];
        bbspi_pkg::REG_START_HOLD:     cfg.start_hold     <= cfg_data[7:0];
        bbspi_pkg::REG_END_HOLD:       cfg.end_hold       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/bbspi_engine.sv]
// ----------------------------------------------------------------------------
// bbspi_engine
// Sequencer state and single-pass next-state logic for one command item.
// ----------------------------------------------------------------------------
module bbspi_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  bbspi_pkg::in_item_t  item,
  input  bbspi_pkg::cfg_t      cfg,
  output bbspi_pkg::out_item_t res
);

  bbspi_pkg::phase_t                   phase, phase_next;
  logic                                busy, busy_next;
  logic [7:0]                          tick_count, tick_count_next;
  logic [7:0]                          hold_count, hold_count_next;
  logic [7:0]                          start_hold_copy, start_hold_copy_next;
  logic [bbspi_pkg::HALF_CNT_W-1:0]    half_bit_index, half_bit_index_next;
  logic [7:0]                          tx_word, tx_word_next;
  logic [7:0]                          rx_word, rx_word_next;
  logic [bbspi_pkg::COUNT_BITS-1:0]    bytes_left, bytes_left_next;

  always_comb begin
    logic                             go;
    logic [bbspi_pkg::HALF_BITS-1:0]  h;
    logic [2:0]                       bit_sel;
    logic [7:0]                       mask;

    phase_next           = phase;
    busy_next            = busy;
    tick_count_next      = tick_count;
    hold_count_next      = hold_count;
    start_hold_copy_next = start_hold_copy;
    half_bit_index_next  = half_bit_index;
    tx_word_next         = tx_word;
    rx_word_next         = rx_word;
    bytes_left_next      = bytes_left;
    res                  = '0;
    go                   = 1'b0;
    h                    = '0;
    bit_sel              = '0;
    mask                 = '0;

    if (item.cmd == bbspi_pkg::CMD_LOAD) begin
      bytes_left_next = bbspi_pkg::COUNT_BITS'(item.byte_count);
      phase_next      = bbspi_pkg::PH_START;
      busy_next       = 1'b1;
    end else if (cfg.soft_enable && busy) begin
      if (tick_count >= cfg.baud_divider) begin
        tick_count_next = '0;
        go = 1'b1;
        if (phase_next == bbspi_pkg::PH_START) begin
          res.start_event      = 1'b1;
          start_hold_copy_next = cfg.start_hold;
          phase_next           = bbspi_pkg::PH_LOAD_HOLD;
          go                   = 1'b0;
        end
        if (go && phase_next == bbspi_pkg::PH_LOAD_HOLD) begin
          hold_count_next = start_hold_copy;
          phase_next      = bbspi_pkg::PH_START_HOLD;
        end
        if (go && phase_next == bbspi_pkg::PH_START_HOLD) begin
          if (hold_count_next != 8'd0) begin
            hold_count_next = hold_count_next - 8'd1;
            go = 1'b0;
          end else begin
            hold_count_next = cfg.end_hold;
            phase_next      = bbspi_pkg::PH_BYTE;
          end
        end
        if (go && phase_next == bbspi_pkg::PH_BYTE) begin
          if (bytes_left == '0) begin
            // end hold: drive idle clock, then finish
            if (hold_count_next != 8'd0) begin
              hold_count_next = hold_count_next - 8'd1;
            end else begin
              phase_next    = bbspi_pkg::PH_START;
              busy_next     = 1'b0;
              res.end_event = 1'b1;
            end
            res.clk_update = 1'b1;
            res.clk_level  = cfg.clock_polarity;
            go = 1'b0;
          end else begin
            tx_word_next        = item.tx_data;
            res.tx_taken        = 1'b1;
            half_bit_index_next = '0;
            phase_next          = bbspi_pkg::PH_SHIFT;
          end
        end
        if (go && phase_next == bbspi_pkg::PH_SHIFT) begin
          h       = half_bit_index_next[bbspi_pkg::HALF_BITS-1:0];
          bit_sel = h[bbspi_pkg::HALF_BITS-1:1];
          mask    = cfg.lsb_first ? (bbspi_pkg::LSB_MASK << bit_sel)
                                  : (bbspi_pkg::MSB_MASK >> bit_sel);
          res.clk_update  = 1'b1;
          res.clk_level   = h[0] ^ cfg.clock_polarity;
          res.mosi_update = 1'b1;
          res.mosi_level  = |(tx_word_next & mask);
          if ((h[0] ^ cfg.clock_phase) == 1'b0) begin
            rx_word_next = item.miso ? (rx_word | mask) : (rx_word & ~mask);
          end
          half_bit_index_next = bbspi_pkg::HALF_CNT_W'(h) + 1'b1;
          if (half_bit_index_next == bbspi_pkg::HALF_CNT_W'(bbspi_pkg::HALF_STEPS)) begin
            res.byte_done   = 1'b1;
            res.rx_byte     = rx_word_next;
            bytes_left_next = bytes_left - 1'b1;
            phase_next      = bbspi_pkg::PH_BYTE;
          end
        end
      end else begin
        tick_count_next = tick_count + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= bbspi_pkg::PH_START;
      busy            <= 1'b0;
      tick_count      <= '0;
      hold_count      <= '0;
      start_hold_copy <= '0;
      half_bit_index  <= '0;
      tx_word         <= '0;
      rx_word         <= '0;
      bytes_left      <= '0;
    end else if (step) begin
      phase           <= phase_next;
      busy            <= busy_next;
      tick_count      <= tick_count_next;
      hold_count      <= hold_count_next;
      start_hold_copy <= start_hold_copy_next;
      half_bit_index  <= half_bit_index_next;
      tx_word         <= tx_word_next;
      rx_word         <= rx_word_next;
      bytes_left      <= bytes_left_next;
    end
  end

  a_load_arms: assert property (@(posedge clk) disable iff (rst)
    step && item.cmd == bbspi_pkg::CMD_LOAD |=> busy && phase == bbspi_pkg::PH_START)
    else $error("load did not arm the sequencer");

  a_end_idles: assert property (@(posedge clk) disable iff (rst)
    step && res.end_event |=> !busy)
    else $error("busy still set after end event");

  a_byte_done_fetch: assert property (@(posedge clk) disable iff (rst)
    step && res.byte_done |=> phase == bbspi_pkg::PH_BYTE)
    else $error("byte completion did not return to byte fetch");

  a_taken_shift: assert property (@(posedge clk) disable iff (rst)
    step && res.tx_taken |=> phase == bbspi_pkg::PH_SHIFT && half_bit_index == 1)
    else $error("latched byte did not start shifting");

  a_half_range: assert property (@(posedge clk) disable iff (rst)
    half_bit_index <= bbspi_pkg::HALF_CNT_W'(bbspi_pkg::HALF_STEPS))
    else $error("half-step index out of range");

endmodule

[rtl/bit_bang_spi_master_core.sv]
// ----------------------------------------------------------------------------
// bit_bang_spi_master_core
// Tick-driven SPI master sequencer: one result per command item.
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------
//   items    | in  | cmd, byte_count, tx_data, miso
//   results  | out | clk/mosi updates and levels, events, rx_byte, tx_taken
//   cfg_*    | in  | register write: index 0..6, 8-bit data
//
// One item per clock sustained while results is ready. An accepted item is
// held in the input register, processed by the sequencer logic, and its
// result is written to the result register. When results stalls, the input
// register holds and items.ready drops only once both registers are full.
// Synchronous reset clears all control and sequencer state; no clearing pass.
// ----------------------------------------------------------------------------
module bit_bang_spi_master_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [bbspi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbspi_pkg::CFG_DATA_W-1:0] cfg_data,
  bbspi_in_if.sink                         items,
  bbspi_out_if.source                      results
);

  bbspi_pkg::cfg_t      cfg;
  bbspi_pkg::in_item_t  in_item;
  bbspi_pkg::out_item_t step_res;
  logic                 in_valid;
  logic                 out_valid;
  bbspi_pkg::out_item_t out_item;
  logic                 step;

  // process the held item when the result register is free or draining
  assign step        = in_valid && (!out_valid || results.ready);
  assign items.ready = !in_valid || step;

  assign results.valid = out_valid;
  assign results.data  = out_item;

  bbspi_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bbspi_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (in_item),
    .cfg  (cfg),
    .res  (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (items.ready) begin
      in_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      in_item <= items.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= step_res;
    end
  end

endmodule
